// ===== rtl/core/teba_pkg.sv =====
package teba_pkg;

	// Width of the two allocation cursors.
	localparam int unsigned CUR_W = 26;

	// Fixed addresses of the region.
	localparam logic [31:0] ALIAS_BIT  = 32'h8000_0000;
	localparam logic [31:0] HEAP_BASE  = 32'h0100_0000;
	localparam logic [31:0] HEAP_LIMIT = 32'h0380_0000;
	localparam logic [31:0] POOL_LIMIT = 32'h03F0_0000;
	localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;
	localparam logic [31:0] MIN_ALIGN  = 32'h0000_0004;
	localparam logic [31:0] NO_BOUND   = 32'hFFFF_FFFF;

	// Request kinds carried on the input user sideband.
	typedef enum logic [1:0] {
		KIND_HEAP    = 2'd0,
		KIND_POOL    = 2'd1,
		KIND_READ    = 2'd2,
		KIND_RESTORE = 2'd3
	} kind_t;

	// One request as held in the input register.
	typedef struct packed {
		kind_t       kind;
		logic [31:0] request_bytes;
		logic [31:0] align_bytes;
		logic [31:0] low_bound;
		logic [31:0] high_bound;
		logic [31:0] restore_point;
	} req_t;

	// One response as held in the result register.
	typedef struct packed {
		logic [31:0] result_value;
		logic        success;
	} rsp_t;

	// New cursor values produced by one request.
	typedef struct packed {
		logic [CUR_W-1:0] heap_top;
		logic [CUR_W-1:0] pool_bottom;
	} cursors_t;

endpackage

// ===== rtl/core/teba_calc.sv =====
module teba_calc (
	input  teba_pkg::req_t     req,
	input  teba_pkg::cursors_t cur,
	output teba_pkg::rsp_t     rsp,
	output teba_pkg::cursors_t nxt
);

	// Heap side: align the heap top up, then add the size.
	logic [32:0] h_align_m1;
	logic [32:0] h_sum;
	logic [32:0] h_aligned;
	logic [33:0] h_end;
	logic        h_align_ok;
	logic        h_ok;

	always_comb begin
		h_align_m1 = 33'(req.align_bytes) - 33'd1;
		h_sum      = 33'(cur.heap_top) + h_align_m1;
		h_aligned  = h_sum & ~h_align_m1;
		h_end      = 34'(h_aligned) + 34'(req.request_bytes);
		h_align_ok = (req.align_bytes >= teba_pkg::MIN_ALIGN)
			&& ((req.align_bytes & (req.align_bytes - 32'd1)) == 32'd0);
		h_ok       = h_align_ok
			&& (h_end <= 34'(teba_pkg::HEAP_LIMIT))
			&& (h_end <= 34'(cur.pool_bottom));
	end

	// Pool side: round to pages and place the block as high as it fits.
	logic [31:0]              p_align;
	logic [31:0]              p_align_m1;
	logic [32:0]              p_round;
	logic [32:0]              p_upper_raw;
	logic [32:0]              p_upper;
	logic [32:0]              p_diff;
	logic [teba_pkg::CUR_W-1:0] p_base;
	logic                     p_ok;

	always_comb begin
		p_align     = (req.align_bytes < teba_pkg::PAGE_BYTES) ?
			teba_pkg::PAGE_BYTES : req.align_bytes;
		p_align_m1  = p_align - 32'd1;
		p_round     = (33'(req.request_bytes) + 33'(teba_pkg::PAGE_BYTES) - 33'd1)
			& ~(33'(teba_pkg::PAGE_BYTES) - 33'd1);
		p_upper_raw = (req.high_bound == teba_pkg::NO_BOUND) ?
			33'(teba_pkg::POOL_LIMIT) : 33'(req.high_bound) + 33'd1;
		p_upper     = (p_upper_raw > 33'(cur.pool_bottom)) ?
			33'(cur.pool_bottom) : p_upper_raw;
		p_diff      = p_upper - p_round;
		p_base      = p_diff[teba_pkg::CUR_W-1:0] & ~p_align_m1[teba_pkg::CUR_W-1:0];
		p_ok        = (req.request_bytes != 32'd0)
			&& ((p_align & p_align_m1) == 32'd0)
			&& (p_round <= p_upper)
			&& (32'(p_base) >= req.low_bound)
			&& (p_base >= cur.heap_top);
	end

	// Restore is allowed only back to a point between heap base and heap top.
	logic r_ok;

	assign r_ok = (req.restore_point >= teba_pkg::HEAP_BASE)
		&& (req.restore_point <= 32'(cur.heap_top));

	// Select the response and cursor update for the request kind.
	always_comb begin
		rsp.result_value = 32'd0;
		rsp.success      = 1'b0;
		nxt              = cur;
		unique case (req.kind)
			teba_pkg::KIND_HEAP: begin
				if (h_ok) begin
					rsp.result_value = h_aligned[31:0];
					rsp.success      = 1'b1;
					nxt.heap_top     = h_end[teba_pkg::CUR_W-1:0];
				end
			end
			teba_pkg::KIND_POOL: begin
				if (p_ok) begin
					rsp.result_value = teba_pkg::ALIAS_BIT | 32'(p_base);
					rsp.success      = 1'b1;
					nxt.pool_bottom  = p_base;
				end
			end
			teba_pkg::KIND_READ: begin
				rsp.result_value = 32'(cur.heap_top);
				rsp.success      = 1'b1;
			end
			teba_pkg::KIND_RESTORE: begin
				if (r_ok) begin
					rsp.result_value = req.restore_point;
					rsp.success      = 1'b1;
					nxt.heap_top     = req.restore_point[teba_pkg::CUR_W-1:0];
				end
			end
		endcase
	end

endmodule

// ===== rtl/core/two_ended_bump_allocator.sv =====
// Two-ended bump allocator.
// Requests arrive on the s_ stream: the request kind on s_tuser and the five
// 32-bit operands on s_tdata. Each request produces exactly one response on
// the m_ stream: the address or checkpoint value and a success flag.
// A transaction that is accepted is captured in the input register; it is
// then evaluated against the heap top and pool bottom cursors, and once the
// result register is free or draining the cursors are updated and the
// response is written into the result register, which drives m_tvalid.
// Throughput is one request per cycle while the receiver does not stall:
// the single evaluation pass between the input register and the result
// register sets that rate, and the cursors are written in the same cycle
// as the result register so the next request sees them.
// When the receiver stalls, the result register holds its response, the
// input register keeps one more request, and s_tready drops only when both
// are full. Reset empties both registers and returns the heap top to
// 0x01000000 and the pool bottom to 0x03F00000.
module two_ended_bump_allocator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] request_bytes, [63:32] align_bytes, [95:64] low_bound,
	// [127:96] high_bound, [159:128] restore_point
	input  logic [159:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] result_value, [32] success, [39:33] zero
	output logic [39:0]  m_tdata
);

	logic                valid_s1;
	teba_pkg::req_t      req_s1;
	logic                valid_s2;
	teba_pkg::rsp_t      rsp_s2;
	teba_pkg::cursors_t  cur_q;
	teba_pkg::rsp_t      rsp_d;
	teba_pkg::cursors_t  cur_d;
	logic                advance;
	logic                s_fire;

	// Move a request forward when the result register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			req_s1.kind          <= teba_pkg::kind_t'(s_tuser);
			req_s1.request_bytes <= s_tdata[31:0];
			req_s1.align_bytes   <= s_tdata[63:32];
			req_s1.low_bound     <= s_tdata[95:64];
			req_s1.high_bound    <= s_tdata[127:96];
			req_s1.restore_point <= s_tdata[159:128];
		end
	end

	// Evaluate the request against the cursors.
	teba_calc u_calc (
		.req (req_s1),
		.cur (cur_q),
		.rsp (rsp_d),
		.nxt (cur_d)
	);

	// Cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.heap_top    <= teba_pkg::HEAP_BASE[teba_pkg::CUR_W-1:0];
			cur_q.pool_bottom <= teba_pkg::POOL_LIMIT[teba_pkg::CUR_W-1:0];
		end else if (advance) begin
			cur_q <= cur_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, rsp_s2.success, rsp_s2.result_value};

	// The heap never drops below its base.
	a_heap_floor: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q.heap_top) >= teba_pkg::HEAP_BASE)
		else $error("heap top below heap base");

	// The two ends never cross.
	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.heap_top <= cur_q.pool_bottom)
		else $error("heap top passed pool bottom");

	// The pool bottom only moves downward.
	a_pool_down: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cur_q.pool_bottom <= $past(cur_q.pool_bottom))
		else $error("pool bottom moved upward");

	// A refused request reports a zero value.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_s2.success) |-> (rsp_s2.result_value == 32'd0))
		else $error("refused transaction carries a nonzero value");

endmodule
